// ===== design/mvs_pkg.sv =====
// shared constants, register indexes and pixel distance function of the seam finder
package mvs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int DIST_W     = 18;
    localparam int SUM_W      = 19;
    localparam int RAD_W      = 20;
    localparam int ROOT_W     = 10;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);
    localparam int ENERGY_W   = 10;
    localparam int COST_W     = 16;
    localparam int SEAM_IDX_W = 6;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

    // sum of squared channel differences of two packed pixels
    function automatic logic [DIST_W-1:0] chan_dist(input logic [PIX_W-1:0] p,
                                                    input logic [PIX_W-1:0] q);
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] d;
        logic [DIST_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = p[k*CHAN_W +: CHAN_W];
            b = q[k*CHAN_W +: CHAN_W];
            d = (a > b) ? (a - b) : (b - a);
            sum = sum + (DIST_W'(d) * DIST_W'(d));
        end
        return sum;
    endfunction

endpackage

// ===== design/min_vertical_seam_finder.sv =====
// minimum vertical seam finder: image store, energy, cost table and seam trace
//
// usage:
//   pixels arrive on the s_axis request channel in raster order, blue in
//   tdata[7:0], green in [15:8], red in [23:16]; tlast marks the final pixel.
//   pixels past image_rows * image_cols are dropped.
//   the final pixel starts the computation; tready stays low until the seam
//   has been delivered. the seam leaves on m_axis, one request per row,
//   bottom row first, tlast on the top row.
//   loading accepts a pixel on every clock that tvalid is high. for each
//   pixel the energy pass makes four pixel ram reads, ten square root steps
//   and one store of the root, and the cost pass makes three reads from the
//   single cost ram read port. the bottom-row minimum search scans every
//   column, and the trace makes three cost reads per row before each output
//   request.
//   if the receiver stalls, the trace holds its current result in the output
//   register until it is taken.
//   reset sets image_rows and image_cols to 64 and empties the load counter;
//   the image memories need no clearing pass. the user must write image_rows
//   and image_cols on the cfg port only while idle; the block does not check it.
module min_vertical_seam_finder #(
    parameter int MAX_ROWS = mvs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mvs_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // blue, green, red
    input  logic                          s_axis_tlast,   // last_pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // seam_row, seam_col, seam_cost
    output logic                          m_axis_tlast,   // last_of_seam
    input  logic                          cfg_we,
    input  logic [mvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mvs_pkg::CFG_W-1:0]     cfg_data
);
    import mvs_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ENERGY,
        S_SQRT,
        S_COST,
        S_FIND,
        S_TRACE,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  rows_cfg_reg;
    logic [CFG_W-1:0]  cols_cfg_reg;
    logic [CW-1:0]     load_idx_reg;
    logic [RCW-1:0]    i_reg;
    logic [CCW-1:0]    j_reg;
    logic [CCW-1:0]    jd_reg;
    logic              vld_reg;
    logic [CW-1:0]     base_reg;
    logic [2:0]        ph_reg;
    logic [PIX_W-1:0]  pa_reg;
    logic [DIST_W-1:0] x_reg;
    logic [ENERGY_W-1:0] e_reg;
    logic [COST_W-1:0] m_reg;
    logic [COST_W-1:0] a_reg;
    logic [COST_W-1:0] b_reg;
    logic [COST_W-1:0] best_reg;
    logic [CCW-1:0]    col_reg;
    logic              out_valid_reg;
    logic [SEAM_IDX_W-1:0] out_row_reg;
    logic [SEAM_IDX_W-1:0] out_col_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              out_last_reg;

    logic [RCW-1:0]    rows_eff;
    logic [CCW-1:0]    cols_eff;
    logic [CW-1:0]     total;
    logic [CW-1:0]     cols_w;
    logic              s_fire;
    logic              m_fire;

    logic [CW-1:0]     up_base;
    logic [CW-1:0]     dn_base;
    logic [CW-1:0]     prev_base;
    logic [CCW-1:0]    j_lf;
    logic [CCW-1:0]    j_rt;
    logic [CCW-1:0]    j_lo;
    logic [CCW-1:0]    j_hi;
    logic [CCW-1:0]    c_lo;
    logic [CCW-1:0]    c_hi;
    logic [CW-1:0]     pix_raddr_w;
    logic [CW-1:0]     cost_raddr_w;
    logic [CW-1:0]     cur_addr_w;

    logic              pix_we;
    logic [PIX_W-1:0]  pix_q;
    logic              en_we;
    logic [ENERGY_W-1:0] en_q;
    logic              cost_we;
    logic [COST_W-1:0] cost_wdata;
    logic [COST_W-1:0] cost_q;

    logic              sq_start;
    logic [SUM_W-1:0]  sq_value;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    logic [COST_W-1:0] m_min;
    logic [COST_W:0]   cost_sum;
    logic [COST_W-1:0] m3;
    logic [CCW-1:0]    col_new;

    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = RCW'(1);
        else if (int'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(rows_cfg_reg);
        if (cols_cfg_reg < CFG_W'(2))
            cols_eff = CCW'(2);
        else if (int'(cols_cfg_reg) > MAX_COLS)
            cols_eff = CCW'(MAX_COLS);
        else
            cols_eff = CCW'(cols_cfg_reg);
    end

    assign cols_w = CW'(cols_eff);
    assign total  = CW'(rows_eff) * cols_w;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // neighbor rows and columns: wrap for the energy reads, clamped for the cost reads
    always_comb
    begin
        up_base   = (i_reg == '0) ? (total - cols_w) : (base_reg - cols_w);
        dn_base   = (i_reg == rows_eff - 1'b1) ? '0 : (base_reg + cols_w);
        prev_base = base_reg - cols_w;
        j_lf      = (j_reg == '0) ? (cols_eff - 1'b1) : (j_reg - 1'b1);
        j_rt      = (j_reg == cols_eff - 1'b1) ? '0 : (j_reg + 1'b1);
        j_lo      = (j_reg == '0) ? j_reg : (j_reg - 1'b1);
        j_hi      = (j_reg == cols_eff - 1'b1) ? j_reg : (j_reg + 1'b1);
        c_lo      = (col_reg == '0) ? col_reg : (col_reg - 1'b1);
        c_hi      = (col_reg == cols_eff - 1'b1) ? col_reg : (col_reg + 1'b1);
        cur_addr_w = base_reg + CW'(j_reg);

        unique case (ph_reg)
            3'd0:    pix_raddr_w = up_base + CW'(j_reg);
            3'd1:    pix_raddr_w = dn_base + CW'(j_reg);
            3'd2:    pix_raddr_w = base_reg + CW'(j_lf);
            default: pix_raddr_w = base_reg + CW'(j_rt);
        endcase

        if (state_reg == S_COST)
        begin
            unique case (ph_reg)
                3'd0:    cost_raddr_w = prev_base + CW'(j_reg);
                3'd1:    cost_raddr_w = prev_base + CW'(j_lo);
                default: cost_raddr_w = prev_base + CW'(j_hi);
            endcase
        end
        else if (state_reg == S_TRACE)
        begin
            unique case (ph_reg)
                3'd0:    cost_raddr_w = base_reg + CW'(c_lo);
                3'd1:    cost_raddr_w = base_reg + CW'(col_reg);
                default: cost_raddr_w = base_reg + CW'(c_hi);
            endcase
        end
        else
        begin
            cost_raddr_w = cur_addr_w;
        end
    end

    // cost update and trace step
    always_comb
    begin
        m_min      = (cost_q < m_reg) ? cost_q : m_reg;
        cost_sum   = (COST_W + 1)'(e_reg) + ((i_reg == '0) ? '0 : (COST_W + 1)'(m_min));
        cost_wdata = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

        m3 = (a_reg < b_reg) ? a_reg : b_reg;
        m3 = (cost_q < m3) ? cost_q : m3;
        if (col_reg == '0)
            col_new = (b_reg < cost_q) ? col_reg : (col_reg + 1'b1);
        else if (col_reg == cols_eff - 1'b1)
            col_new = (b_reg < a_reg) ? col_reg : (col_reg - 1'b1);
        else if (m3 == b_reg)
            col_new = col_reg;
        else if (m3 == a_reg)
            col_new = col_reg - 1'b1;
        else
            col_new = col_reg + 1'b1;
    end

    assign pix_we   = s_fire && (load_idx_reg < total);
    assign en_we    = (state_reg == S_SQRT) && sq_done;
    assign cost_we  = (state_reg == S_COST) && (ph_reg == 3'd3);
    assign sq_start = (state_reg == S_ENERGY) && (ph_reg == 3'd4);
    assign sq_value = SUM_W'(x_reg) + SUM_W'(chan_dist(pa_reg, pix_q));

    mvs_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (load_idx_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (pix_raddr_w[AW-1:0]),
        .rdata (pix_q)
    );

    mvs_ram #(.WIDTH(ENERGY_W), .DEPTH(DEPTH)) u_energy_ram (
        .clk   (clk),
        .we    (en_we),
        .waddr (cur_addr_w[AW-1:0]),
        .wdata (ENERGY_W'(sq_root)),
        .raddr (cur_addr_w[AW-1:0]),
        .rdata (en_q)
    );

    mvs_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cur_addr_w[AW-1:0]),
        .wdata (cost_wdata),
        .raddr (cost_raddr_w[AW-1:0]),
        .rdata (cost_q)
    );

    mvs_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rows_cfg_reg  <= CFG_W'(64);
            cols_cfg_reg  <= CFG_W'(64);
            load_idx_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            jd_reg        <= '0;
            vld_reg       <= 1'b0;
            base_reg      <= '0;
            ph_reg        <= '0;
            pa_reg        <= '0;
            x_reg         <= '0;
            e_reg         <= '0;
            m_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            best_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_cost_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_ROWS: rows_cfg_reg <= cfg_data;
                    REG_IMAGE_COLS: cols_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (s_axis_tlast)
                        begin
                            load_idx_reg <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            base_reg     <= '0;
                            ph_reg       <= '0;
                            state_reg    <= S_ENERGY;
                        end
                        else if (load_idx_reg < total)
                        begin
                            load_idx_reg <= load_idx_reg + 1'b1;
                        end
                    end
                end

                S_ENERGY:
                begin
                    unique case (ph_reg)
                        3'd1:    pa_reg <= pix_q;
                        3'd2:    x_reg  <= chan_dist(pa_reg, pix_q);
                        3'd3:    pa_reg <= pix_q;
                        default: ;
                    endcase
                    if (ph_reg == 3'd4)
                        state_reg <= S_SQRT;
                    else
                        ph_reg <= ph_reg + 1'b1;
                end

                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        ph_reg <= '0;
                        if (j_reg == cols_eff - 1'b1)
                        begin
                            j_reg <= '0;
                            if (i_reg == rows_eff - 1'b1)
                            begin
                                i_reg     <= '0;
                                base_reg  <= '0;
                                state_reg <= S_COST;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                base_reg  <= base_reg + cols_w;
                                state_reg <= S_ENERGY;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_ENERGY;
                        end
                    end
                end

                S_COST:
                begin
                    unique case (ph_reg)
                        3'd1:
                        begin
                            m_reg <= cost_q;
                            e_reg <= en_q;
                        end
                        3'd2:    m_reg <= m_min;
                        default: ;
                    endcase
                    if (ph_reg == 3'd3)
                    begin
                        ph_reg <= '0;
                        if (j_reg == cols_eff - 1'b1)
                        begin
                            j_reg <= '0;
                            if (i_reg == rows_eff - 1'b1)
                            begin
                                vld_reg   <= 1'b0;
                                state_reg <= S_FIND;
                            end
                            else
                            begin
                                i_reg    <= i_reg + 1'b1;
                                base_reg <= base_reg + cols_w;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end

                S_FIND:
                begin
                    vld_reg <= (j_reg < cols_eff);
                    jd_reg  <= j_reg;
                    if (j_reg < cols_eff)
                        j_reg <= j_reg + 1'b1;
                    if (vld_reg && ((jd_reg == '0) || (cost_q < best_reg)))
                    begin
                        best_reg <= cost_q;
                        col_reg  <= jd_reg;
                    end
                    if ((j_reg == cols_eff) && !vld_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= SEAM_IDX_W'(i_reg);
                        out_col_reg   <= SEAM_IDX_W'(col_reg);
                        out_cost_reg  <= best_reg;
                        out_last_reg  <= (i_reg == '0);
                        state_reg     <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (m_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        if (i_reg == '0)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg - 1'b1;
                            base_reg  <= base_reg - cols_w;
                            ph_reg    <= '0;
                            state_reg <= S_TRACE;
                        end
                    end
                end

                S_TRACE:
                begin
                    unique case (ph_reg)
                        3'd1:    a_reg <= cost_q;
                        3'd2:    b_reg <= cost_q;
                        default: ;
                    endcase
                    if (ph_reg == 3'd3)
                    begin
                        col_reg       <= col_new;
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= SEAM_IDX_W'(i_reg);
                        out_col_reg   <= SEAM_IDX_W'(col_new);
                        out_last_reg  <= (i_reg == '0);
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end

                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_cost_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a seam element is pending");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_axis_tlast) |=> s_axis_tready)
        else $error("block did not return to loading after the top row");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_idx_reg <= total)
        else $error("load index ran past the image size");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT))
        else $error("square root finished outside the energy pass");

endmodule

// ===== design/mvs_ram.sv =====
// generic simple dual port ram with registered read
module mvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mvs_isqrt.sv =====
// iterative floor square root, two radicand bits per cycle
module mvs_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mvs_pkg::SUM_W-1:0] value,
    output logic                      done,
    output logic [mvs_pkg::ROOT_W-1:0] root
);
    import mvs_pkg::*;

    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_W+2:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_W+2:0]     shifted;
    logic [ROOT_W+2:0]     trial;

    always_comb
    begin
        shifted = {rem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= RAD_W'(value);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= SQRT_CNT_W'(SQRT_STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (shifted >= trial)
                begin
                    rem_reg  <= shifted - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
